// ----- rtl/lsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the serial LED strip encoder.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_W          = 5;
    localparam int IDX_W          = 9;
    localparam int LEN_W          = 10;
    localparam int DUTY_W         = 8;
    localparam int COLOUR_W       = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    localparam logic [LEN_W-1:0]  STRIP_LENGTH_RST = 10'd512;
    localparam logic [DUTY_W-1:0] ONE_DUTY_RST     = 8'd38;
    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST    = 8'd19;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_TICK  = 2'd2
    } lsp_cmd_code_t;

    typedef enum logic [1:0] {
        REG_STRIP_LENGTH = 2'd0,
        REG_ONE_DUTY     = 2'd1,
        REG_ZERO_DUTY    = 2'd2
    } lsp_reg_idx_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_TICK  = 2'd2
    } lsp_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR   = 2'd0,
        ST_IDLE    = 2'd1,
        ST_FILL    = 2'd2,
        ST_TICK_RD = 2'd3
    } lsp_state_t;

    typedef struct packed {
        lsp_op_t              op;
        logic [IDX_W-1:0]     idx;
        logic [COLOUR_W-1:0]  colour;
        logic [LEN_W-1:0]     fill_count;
    } lsp_cmd_t;

endpackage

// ----- rtl/lsp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lsp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_queue
// Two entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lsp_pkg::lsp_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output lsp_pkg::lsp_cmd_t pop_data,
    output logic              empty
);
    import lsp_pkg::*;

    lsp_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/lsp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_front
// Accepts input transactions, drops unused codes and writes to bad indexes, and
// queues the rest with the fill length fixed at acceptance.
// ----------------------------------------------------------------------------
module lsp_front #(
    parameter int MAX_PIXELS = 512
) (
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [lsp_pkg::IDX_W-1:0]  pixel_index,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic [lsp_pkg::LEN_W-1:0]  strip_length,
    input  logic                       clear_done,
    input  logic                       q_full,
    output logic                       q_push,
    output lsp_pkg::lsp_cmd_t          q_data
);
    import lsp_pkg::*;

    logic accept;
    logic idx_ok;

    assign in_ready = clear_done && !q_full;
    assign accept   = in_valid && in_ready;
    assign idx_ok   = (32'(pixel_index) < MAX_PIXELS);

    always_comb
    begin
        q_data.idx        = pixel_index;
        q_data.colour     = {green, red, blue};
        q_data.fill_count = (32'(strip_length) > MAX_PIXELS) ? LEN_W'(MAX_PIXELS)
                                                              : strip_length;
        q_data.op         = OP_TICK;
        q_push            = 1'b0;
        case (command)
            CMD_WRITE:
            begin
                q_data.op = OP_WRITE;
                q_push    = accept && idx_ok;
            end
            CMD_FILL:
            begin
                q_data.op = OP_FILL;
                q_push    = accept;
            end
            CMD_TICK:
            begin
                q_data.op = OP_TICK;
                q_push    = accept;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lsp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_back
// Carries out queued commands on the pixel RAM, walks the slot position and
// holds the output register.
// ----------------------------------------------------------------------------
module lsp_back #(
    parameter int MAX_PIXELS  = 512,
    parameter int RESET_SLOTS = 216,
    parameter int ADDR_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsp_pkg::lsp_cmd_t           q_data,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        clear_done,
    input  logic [lsp_pkg::LEN_W-1:0]   strip_length,
    input  logic [lsp_pkg::DUTY_W-1:0]  one_duty,
    input  logic [lsp_pkg::DUTY_W-1:0]  zero_duty,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output logic [lsp_pkg::COLOUR_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0]           ram_raddr,
    input  logic [lsp_pkg::COLOUR_W-1:0] ram_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lsp_pkg::DUTY_W-1:0]  pwm_compare,
    output logic                        frame_end
);
    import lsp_pkg::*;

    localparam int GAP_W = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

    lsp_state_t           state_reg;
    lsp_state_t           state_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [LEN_W-1:0]     fill_count_reg;
    logic [LEN_W-1:0]     fill_count_next;
    logic [COLOUR_W-1:0]  fill_colour_reg;
    logic [COLOUR_W-1:0]  fill_colour_next;
    logic [ADDR_W-1:0]    pix_reg;
    logic [ADDR_W-1:0]    pix_next;
    logic [BIT_W-1:0]     bit_reg;
    logic [BIT_W-1:0]     bit_next;
    logic [GAP_W-1:0]     gap_reg;
    logic [GAP_W-1:0]     gap_next;
    logic                 in_gap_reg;
    logic                 in_gap_next;
    logic [BIT_W-1:0]     sel_reg;
    logic [BIT_W-1:0]     sel_next;
    logic                 used_reg;
    logic                 used_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DUTY_W-1:0]    pwm_compare_reg;
    logic [DUTY_W-1:0]    pwm_compare_next;
    logic                 frame_end_reg;
    logic                 frame_end_next;

    assign clear_done  = (state_reg != ST_CLEAR);
    assign out_valid   = out_valid_reg;
    assign pwm_compare = pwm_compare_reg;
    assign frame_end   = frame_end_reg;

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        fill_count_next  = fill_count_reg;
        fill_colour_next = fill_colour_reg;
        pix_next         = pix_reg;
        bit_next         = bit_reg;
        gap_next         = gap_reg;
        in_gap_next      = in_gap_reg;
        sel_next         = sel_reg;
        used_next        = used_reg;
        out_valid_next   = out_valid_reg;
        pwm_compare_next = pwm_compare_reg;
        frame_end_next   = frame_end_reg;
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = '0;
        ram_raddr        = pix_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == ADDR_W'(MAX_PIXELS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.op)
                        OP_WRITE:
                        begin
                            q_pop     = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(q_data.idx);
                            ram_wdata = q_data.colour;
                        end
                        OP_FILL:
                        begin
                            q_pop = 1'b1;
                            if (q_data.fill_count != '0)
                            begin
                                addr_next        = '0;
                                fill_count_next  = q_data.fill_count;
                                fill_colour_next = q_data.colour;
                                state_next       = ST_FILL;
                            end
                        end
                        OP_TICK:
                        begin
                            if (!out_valid_reg)
                            begin
                                q_pop = 1'b1;
                                if (in_gap_reg)
                                begin
                                    out_valid_next   = 1'b1;
                                    pwm_compare_next = '0;
                                    frame_end_next   = 1'b0;
                                    if (gap_reg == GAP_W'(RESET_SLOTS - 1))
                                    begin
                                        frame_end_next = 1'b1;
                                        in_gap_next    = 1'b0;
                                        pix_next       = '0;
                                        bit_next       = '0;
                                        gap_next       = '0;
                                    end
                                    else
                                    begin
                                        gap_next = gap_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    sel_next   = BIT_W'(BITS_PER_PIXEL - 1) - bit_reg;
                                    used_next  = (32'(pix_reg) < 32'(strip_length));
                                    state_next = ST_TICK_RD;
                                    if (bit_reg == BIT_W'(BITS_PER_PIXEL - 1))
                                    begin
                                        bit_next = '0;
                                        if (pix_reg == ADDR_W'(MAX_PIXELS - 1))
                                        begin
                                            in_gap_next = 1'b1;
                                            gap_next    = '0;
                                        end
                                        else
                                        begin
                                            pix_next = pix_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = fill_colour_reg;
                if (32'(addr_reg) + 32'd1 == 32'(fill_count_reg))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_TICK_RD:
            begin
                out_valid_next   = 1'b1;
                pwm_compare_next = (used_reg && ram_rdata[sel_reg]) ? one_duty : zero_duty;
                frame_end_next   = 1'b0;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            pix_reg       <= '0;
            bit_reg       <= '0;
            gap_reg       <= '0;
            in_gap_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pix_reg       <= pix_next;
            bit_reg       <= bit_next;
            gap_reg       <= gap_next;
            in_gap_reg    <= in_gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_count_reg  <= fill_count_next;
        fill_colour_reg <= fill_colour_next;
        sel_reg         <= sel_next;
        used_reg        <= used_next;
        pwm_compare_reg <= pwm_compare_next;
        frame_end_reg   <= frame_end_next;
    end

endmodule

// ----- rtl/led_strip_pwm_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_pwm_encoder
// Pixel colour store and bit slot compare value generator for a serial LED
// strip.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_ready        command pixel_index red green blue
//   out      output     out_valid / out_ready      pwm_compare frame_end
//   cfg      input      psel penable pwrite pready paddr pwdata prdata
//
// a write hits the RAM on its pop, a pixel slot tick goes through ST_TICK_RD
// (registered RAM read), a reset gap tick does not, fill writes min(strip_length,
// MAX_PIXELS) pixels, one RAM write per pixel; queued items wait in queue registers
// after reset a clearing pass zeroes all MAX_PIXELS RAM entries, in_ready low
// a two entry queue keeps in_ready up while the back end is busy, until it is full
// a tick waits in the queue while an earlier result is not yet taken
// ----------------------------------------------------------------------------
module led_strip_pwm_encoder #(
    parameter int MAX_PIXELS  = 512,
    parameter int RESET_SLOTS = 216
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [8:0]  pixel_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pwm_compare,
    output logic        frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsp_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [LEN_W-1:0]    strip_length_reg;
    logic [DUTY_W-1:0]   one_duty_reg;
    logic [DUTY_W-1:0]   zero_duty_reg;
    logic                cfg_write;
    lsp_reg_idx_t        reg_idx;

    logic                clear_done;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    lsp_cmd_t            q_in;
    lsp_cmd_t            q_out;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [COLOUR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [COLOUR_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = lsp_reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (reg_idx)
            REG_STRIP_LENGTH: prdata = PDATA_W'(strip_length_reg);
            REG_ONE_DUTY:     prdata = PDATA_W'(one_duty_reg);
            REG_ZERO_DUTY:    prdata = PDATA_W'(zero_duty_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= STRIP_LENGTH_RST;
            one_duty_reg     <= ONE_DUTY_RST;
            zero_duty_reg    <= ZERO_DUTY_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_STRIP_LENGTH: strip_length_reg <= pwdata[LEN_W-1:0];
                REG_ONE_DUTY:     one_duty_reg     <= pwdata[DUTY_W-1:0];
                REG_ZERO_DUTY:    zero_duty_reg    <= pwdata[DUTY_W-1:0];
                default:          strip_length_reg <= strip_length_reg;
            endcase
        end
    end

    lsp_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .strip_length (strip_length_reg),
        .clear_done   (clear_done),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    lsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lsp_back #(
        .MAX_PIXELS  (MAX_PIXELS),
        .RESET_SLOTS (RESET_SLOTS),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .clear_done   (clear_done),
        .strip_length (strip_length_reg),
        .one_duty     (one_duty_reg),
        .zero_duty    (zero_duty_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_compare  (pwm_compare),
        .frame_end    (frame_end)
    );

    lsp_ram #(
        .WIDTH  (COLOUR_W),
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !in_ready)
        else $error("transaction accepted during clearing pass");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (pwm_compare == '0))
        else $error("frame end with nonzero compare value");
`endif

endmodule
